[sv/tch_pkg.sv]
// Shared constants, types and the arctangent table of the heading core.
package tch_pkg;

	localparam int AngleFracBits = 6;
	localparam int CordicIters   = 16;
	localparam int SqrtSteps     = 15;
	localparam int XW            = 48;
	localparam int ZW            = 26;
	localparam int AngW          = AngleFracBits + 11;
	localparam int RW            = AngleFracBits + 13;

	localparam logic signed [ZW-1:0] Z180     = ZW'(180 * 65536);
	localparam logic signed [ZW-1:0] ZRound   = ZW'(1 << (15 - AngleFracBits));
	localparam logic signed [RW-1:0] HalfTurn = RW'(180 << AngleFracBits);
	localparam logic signed [RW-1:0] FullTurn = RW'(360 << AngleFracBits);

	typedef struct packed {
		logic signed [15:0] sr;
		logic signed [15:0] sp;
		logic signed [15:0] mx;
		logic signed [15:0] my;
		logic signed [15:0] mz;
	} side_t;

	// atan(2^-i) in degrees, Q16
	function automatic logic signed [ZW-1:0] atan_deg(input int i);
		logic signed [ZW-1:0] a;
		case (i)
			0: a = ZW'(2949120);
			1: a = ZW'(1740967);
			2: a = ZW'(919879);
			3: a = ZW'(466945);
			4: a = ZW'(234379);
			5: a = ZW'(117304);
			6: a = ZW'(58666);
			7: a = ZW'(29335);
			8: a = ZW'(14668);
			9: a = ZW'(7334);
			10: a = ZW'(3667);
			11: a = ZW'(1833);
			12: a = ZW'(917);
			13: a = ZW'(458);
			14: a = ZW'(229);
			15: a = ZW'(115);
			16: a = ZW'(57);
			17: a = ZW'(29);
			18: a = ZW'(14);
			19: a = ZW'(7);
			20: a = ZW'(4);
			21: a = ZW'(2);
			22: a = ZW'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

[sv/tch_sine.sv]
// Quaternion products, saturated Q14 sines and the square-root arguments.
module tch_sine import tch_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] mag_x,
	input  logic signed [15:0] mag_y,
	input  logic signed [15:0] mag_z,
	output logic               out_v,
	output side_t              side,
	output logic [28:0]        arg_r,
	output logic [28:0]        arg_p
);

	localparam logic signed [33:0] One28 = 34'sd268435456;

	function automatic logic signed [15:0] sat_round(input logic signed [33:0] s);
		logic signed [33:0] c;
		if (s > One28)
			c = One28;
		else if (s < -One28)
			c = -One28;
		else
			c = s;
		c = c + 34'sd8192;
		return c[29:14];
	endfunction

	logic signed [31:0] ra_s1, rb_s1, pa_s1, pb_s1;
	logic signed [15:0] mx_s1, my_s1, mz_s1;
	logic               v_s1, v_s2, v_s3;
	side_t              side_s2, side_s3;
	logic [28:0]        argr_s3, argp_s3;
	logic signed [33:0] r28, p28;
	logic signed [31:0] sqr, sqp;

	assign r28 = (34'(ra_s1) + 34'(rb_s1)) <<< 1;
	assign p28 = (34'(pa_s1) - 34'(pb_s1)) <<< 1;
	assign sqr = 32'(side_s2.sr) * 32'(side_s2.sr);
	assign sqp = 32'(side_s2.sp) * 32'(side_s2.sp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ra_s1      <= 32'(quat_w) * 32'(quat_x);
			rb_s1      <= 32'(quat_y) * 32'(quat_z);
			pa_s1      <= 32'(quat_w) * 32'(quat_y);
			pb_s1      <= 32'(quat_x) * 32'(quat_z);
			mx_s1      <= mag_x;
			my_s1      <= mag_y;
			mz_s1      <= mag_z;
			side_s2.sr <= sat_round(r28);
			side_s2.sp <= sat_round(p28);
			side_s2.mx <= mx_s1;
			side_s2.my <= my_s1;
			side_s2.mz <= mz_s1;
			side_s3    <= side_s2;
			argr_s3    <= 29'(32'sd268435456 - sqr);
			argp_s3    <= 29'(32'sd268435456 - sqp);
		end
	end

	assign out_v = v_s3;
	assign side  = side_s3;
	assign arg_r = argr_s3;
	assign arg_p = argp_s3;

endmodule

[sv/tch_isqrt.sv]
// Pipelined integer square root, one root bit per stage, two lanes.
module tch_isqrt import tch_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  side_t              in_side,
	input  logic [28:0]        arg_r,
	input  logic [28:0]        arg_p,
	output logic               out_v,
	output side_t              out_side,
	output logic signed [15:0] cos_r,
	output logic signed [15:0] cos_p
);

	typedef struct packed {
		logic [30:0] n;
		logic [30:0] root;
	} lane_t;

	function automatic lane_t step(input lane_t a, input logic [30:0] b);
		lane_t o;
		if (a.n >= a.root + b) begin
			o.n    = a.n - (a.root + b);
			o.root = (a.root >> 1) + b;
		end else begin
			o.n    = a.n;
			o.root = a.root >> 1;
		end
		return o;
	endfunction

	logic  v_s    [1:SqrtSteps];
	side_t side_s [1:SqrtSteps];
	lane_t r_s    [1:SqrtSteps];
	lane_t p_s    [1:SqrtSteps];

	for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
		localparam logic [30:0] Bit = 31'(1) << (2 * (SqrtSteps - 1 - k));
		logic  cur_v;
		side_t cur_side;
		lane_t cur_r, cur_p;
		if (k == 0) begin : g_first
			assign cur_v    = in_v;
			assign cur_side = in_side;
			assign cur_r    = '{n: 31'(arg_r), root: '0};
			assign cur_p    = '{n: 31'(arg_p), root: '0};
		end else begin : g_mid
			assign cur_v    = v_s[k];
			assign cur_side = side_s[k];
			assign cur_r    = r_s[k];
			assign cur_p    = p_s[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k+1] <= 1'b0;
			else if (en)
				v_s[k+1] <= cur_v;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= cur_side;
				r_s[k+1]    <= step(cur_r, Bit);
				p_s[k+1]    <= step(cur_p, Bit);
			end
		end
	end

	assign out_v    = v_s[SqrtSteps];
	assign out_side = side_s[SqrtSteps];
	assign cos_r    = 16'(r_s[SqrtSteps].root);
	assign cos_p    = 16'(p_s[SqrtSteps].root);

endmodule

[sv/tch_rotate.sv]
// Rotation of the magnetic vector into the horizontal plane and CORDIC prerotation.
module tch_rotate import tch_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_v,
	input  side_t                side,
	input  logic signed [15:0]   cos_r,
	input  logic signed [15:0]   cos_p,
	output logic                 out_v,
	output logic signed [XW-1:0] x0,
	output logic signed [XW-1:0] y0,
	output logic signed [ZW-1:0] z0,
	output logic                 zero
);

	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [31:0] srsp_s1, srcp_s1, mxcp_s1, mzsp_s1, mycr_s1;
	logic signed [15:0] mx_s1, mz_s1;
	logic signed [32:0] hxs_s2;
	logic signed [47:0] t1_s2, t3_s2;
	logic signed [31:0] mycr_s2;
	logic signed [XW-1:0] hx_s3, hy_s3;
	logic signed [XW-1:0] x_s4, y_s4;
	logic signed [ZW-1:0] z_s4;
	logic                 zero_s4;
	logic                 neg;

	assign neg = hx_s3 < 0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			srsp_s1 <= 32'(side.sr) * 32'(side.sp);
			srcp_s1 <= 32'(side.sr) * 32'(cos_p);
			mxcp_s1 <= 32'(side.mx) * 32'(cos_p);
			mzsp_s1 <= 32'(side.mz) * 32'(side.sp);
			mycr_s1 <= 32'(side.my) * 32'(cos_r);
			mx_s1   <= side.mx;
			mz_s1   <= side.mz;
			hxs_s2  <= 33'(mxcp_s1) + 33'(mzsp_s1);
			t1_s2   <= 48'(mx_s1) * 48'(srsp_s1);
			t3_s2   <= 48'(mz_s1) * 48'(srcp_s1);
			mycr_s2 <= mycr_s1;
			hx_s3   <= XW'(hxs_s2) <<< 14;
			hy_s3   <= XW'(t1_s2) + (XW'(mycr_s2) <<< 14) - XW'(t3_s2);
			zero_s4 <= (hx_s3 == '0) && (hy_s3 == '0);
			x_s4    <= neg ? -hx_s3 : hx_s3;
			y_s4    <= neg ? -hy_s3 : hy_s3;
			// left half-plane: flip the vector, start from +-180 degrees
			if (!neg)
				z_s4 <= '0;
			else if (hy_s3 >= 0)
				z_s4 <= Z180;
			else
				z_s4 <= -Z180;
		end
	end

	assign out_v = v_s4;
	assign x0    = x_s4;
	assign y0    = y_s4;
	assign z0    = z_s4;
	assign zero  = zero_s4;

endmodule

[sv/tch_cordic.sv]
// Vectoring CORDIC stages, angle rounding, offset and wrap to half a turn.
module tch_cordic import tch_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_v,
	input  logic signed [XW-1:0] x0,
	input  logic signed [XW-1:0] y0,
	input  logic signed [ZW-1:0] z0,
	input  logic                 zero,
	input  logic signed [14:0]   offset,
	output logic                 out_v,
	output logic signed [14:0]   heading
);

	logic                 v_s    [1:CordicIters];
	logic                 zf_s   [1:CordicIters];
	logic signed [XW-1:0] x_s    [1:CordicIters];
	logic signed [XW-1:0] y_s    [1:CordicIters];
	logic signed [ZW-1:0] z_s    [1:CordicIters];

	for (genvar i = 0; i < CordicIters; i++) begin : g_iter
		localparam logic signed [ZW-1:0] Atan = atan_deg(i);
		logic                 cv, cz;
		logic signed [XW-1:0] cx, cy;
		logic signed [ZW-1:0] cw;
		if (i == 0) begin : g_first
			assign cv = in_v;
			assign cz = zero;
			assign cx = x0;
			assign cy = y0;
			assign cw = z0;
		end else begin : g_mid
			assign cv = v_s[i];
			assign cz = zf_s[i];
			assign cx = x_s[i];
			assign cy = y_s[i];
			assign cw = z_s[i];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (en)
				v_s[i+1] <= cv;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				zf_s[i+1] <= cz;
				if (cy >= 0) begin
					x_s[i+1] <= cx + (cy >>> i);
					y_s[i+1] <= cy - (cx >>> i);
					z_s[i+1] <= cw + Atan;
				end else begin
					x_s[i+1] <= cx - (cy >>> i);
					y_s[i+1] <= cy + (cx >>> i);
					z_s[i+1] <= cw - Atan;
				end
			end
		end
	end

	logic                 v_r1, v_r2;
	logic signed [RW-1:0] t_r1;
	logic signed [14:0]   head_r2;
	logic signed [ZW-1:0] zsel, zrnd;
	logic signed [AngW-1:0] ang;
	logic signed [RW-1:0] wrapped;

	assign zsel = zf_s[CordicIters] ? '0 : z_s[CordicIters];
	assign zrnd = (zsel + ZRound) >>> (16 - AngleFracBits);
	assign ang  = AngW'(zrnd);

	always_comb begin
		if (t_r1 < 0)
			wrapped = t_r1 + FullTurn - HalfTurn;
		else if (t_r1 >= FullTurn)
			wrapped = t_r1 - FullTurn - HalfTurn;
		else
			wrapped = t_r1 - HalfTurn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_r1 <= 1'b0;
			v_r2 <= 1'b0;
		end else if (en) begin
			v_r1 <= v_s[CordicIters];
			v_r2 <= v_r1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_r1    <= RW'(ang) - RW'(offset) + HalfTurn;
			head_r2 <= 15'(wrapped);
		end
	end

	assign out_v   = v_r2;
	assign heading = head_r2;

endmodule

[sv/tilt_compensated_heading_core.sv]
// Top level of the tilt-compensated heading core.
// Input channel: in_valid/in_stall with one quaternion (Q2.14) and one
// magnetometer vector per beat. Output channel: out_valid/out_stall with
// the heading in 1/64 degree units, wrapped to [-180,180).
// cfg_we/cfg_wdata write the heading offset, subtracted before the wrap;
// write it only while no beat is in flight.
// An accepted input beat passes in order through the sine stages, the
// bit-per-stage square-root stages, the rotation stages, 16 CORDIC stages
// and the rounding and wrap registers before out_valid. A new beat is taken
// every cycle while in_stall is low; the whole pipe advances in lockstep.
// When the receiver stalls with a result pending, the pipe freezes and
// in_stall goes high in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and sets the offset to zero.
module tilt_compensated_heading_core import tch_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] mag_x,
	input  logic signed [15:0] mag_y,
	input  logic signed [15:0] mag_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [14:0] heading,
	input  logic               cfg_we,
	input  logic signed [14:0] cfg_wdata
);

	logic               en;
	logic signed [14:0] offset_q;
	logic               sin_v, sq_v, rot_v;
	side_t              sin_side, sq_side;
	logic [28:0]        arg_r, arg_p;
	logic signed [15:0] cos_r, cos_p;
	logic signed [XW-1:0] x0, y0;
	logic signed [ZW-1:0] z0;
	logic               zero;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			offset_q <= '0;
		else if (cfg_we)
			offset_q <= cfg_wdata;
	end

	tch_sine u_sine (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(in_valid),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.mag_x(mag_x), .mag_y(mag_y), .mag_z(mag_z),
		.out_v(sin_v), .side(sin_side), .arg_r(arg_r), .arg_p(arg_p)
	);

	tch_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(sin_v), .in_side(sin_side),
		.arg_r(arg_r), .arg_p(arg_p),
		.out_v(sq_v), .out_side(sq_side), .cos_r(cos_r), .cos_p(cos_p)
	);

	tch_rotate u_rotate (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(sq_v), .side(sq_side),
		.cos_r(cos_r), .cos_p(cos_p),
		.out_v(rot_v), .x0(x0), .y0(y0), .z0(z0), .zero(zero)
	);

	tch_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(rot_v),
		.x0(x0), .y0(y0), .z0(z0), .zero(zero), .offset(offset_q),
		.out_v(out_valid), .heading(heading)
	);

endmodule
